// ===== hw/rtl/nphc_pkg.sv =====
// ----------------------------------------------------------------------------
// nphc_pkg
// Shared types and constants for the nearest point hit counter.
// ----------------------------------------------------------------------------
package nphc_pkg;

  localparam int MAX_REFS = 64;
  localparam int IDX_W    = $clog2(MAX_REFS);
  localparam int TOT_W    = IDX_W + 1;
  localparam int POS_W    = 32;
  localparam int CNT_W    = 32;

  typedef enum logic [1:0] {
    FN_LOAD     = 2'd0,
    FN_CLASSIFY = 2'd1,
    FN_READOUT  = 2'd2,
    FN_CLEAR    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DUP   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CMP,
    BK_SEL,
    BK_EXEC,
    BK_READ
  } bk_state_t;

  typedef struct packed {
    func_t            func;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [TOT_W-1:0]    total;
    logic [MAX_REFS-1:0] valid;
  } tbl_stat_t;

endpackage

// ===== hw/rtl/nearest_point_hit_counter.sv =====
// ----------------------------------------------------------------------------
// nearest_point_hit_counter
// Sorted reference table with nearest-point classification and hit counts.
// ----------------------------------------------------------------------------
// A two-entry command queue takes items while the execution side works. Load
// and classify pass the execution side's dequeue, compare-all-cells, select-
// neighbors and execute steps; clear takes only the dequeue and compare steps,
// and readout takes all of these plus a walk step per stored entry. The execution
// side works on one item at a time and takes no new command until the last is
// through; results leave through an output register that may stall independently.
module nearest_point_hit_counter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 func,
  input  logic [nphc_pkg::POS_W-1:0] position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [nphc_pkg::POS_W-1:0] ref_position,
  output logic [nphc_pkg::CNT_W-1:0] hit_count,
  output logic [nphc_pkg::IDX_W-1:0] ref_index,
  output logic [1:0]                 status,
  output logic                       last
);
  import nphc_pkg::*;

  logic      cmd_valid;
  logic      cmd_ready;
  cmd_t      cmd;
  tbl_stat_t tbl_stat;

  nphc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .position  (position),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  nphc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ref_position (ref_position),
    .hit_count    (hit_count),
    .ref_index    (ref_index),
    .status       (status),
    .last         (last),
    .tbl_stat     (tbl_stat)
  );

  // entry count tracks the valid bits
  a_total: assert property (@(posedge clk) disable iff (rst)
    TOT_W'($countones(tbl_stat.valid)) == tbl_stat.total)
    else $error("entry total out of step with valid cells");

  // valid cells always form a prefix of the row
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (tbl_stat.valid & (tbl_stat.valid + MAX_REFS'(1))) == '0)
    else $error("valid cells not contiguous");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== hw/rtl/nphc_front.sv =====
// ----------------------------------------------------------------------------
// nphc_front
// Input side: decodes the function code and queues commands (two entries).
// ----------------------------------------------------------------------------
module nphc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 func,
  input  logic [nphc_pkg::POS_W-1:0] position,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output nphc_pkg::cmd_t             cmd
);
  import nphc_pkg::*;

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_stall  = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rp];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{func: func_t'(func), pos: position};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hw/rtl/nphc_back.sv =====
// ----------------------------------------------------------------------------
// nphc_back
// Execution side: sorted row of reference cells, compare/select/execute
// sequencer, readout walk and the output register.
// ----------------------------------------------------------------------------
module nphc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  nphc_pkg::cmd_t             cmd,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [nphc_pkg::POS_W-1:0] ref_position,
  output logic [nphc_pkg::CNT_W-1:0] hit_count,
  output logic [nphc_pkg::IDX_W-1:0] ref_index,
  output logic [1:0]                 status,
  output logic                       last,
  output nphc_pkg::tbl_stat_t        tbl_stat
);
  import nphc_pkg::*;

  logic [POS_W-1:0]    pos_tab [MAX_REFS];
  logic [CNT_W-1:0]    cnt_tab [MAX_REFS];
  logic [MAX_REFS-1:0] valid;
  logic [TOT_W-1:0]    total;
  bk_state_t           state, state_next;
  cmd_t                cur;
  logic [MAX_REFS-1:0] lt;
  logic [TOT_W-1:0]    rank;
  logic                has_lo, has_hi;
  logic [POS_W-1:0]    plo, phi;
  logic [CNT_W-1:0]    chi, clo;
  logic [TOT_W-1:0]    rd;

  logic [MAX_REFS-1:0] lt_c, lo_oh, hi_oh;
  logic [POS_W-1:0]    plo_c, phi_c;
  logic [CNT_W-1:0]    clo_c, chi_c;
  logic                out_free, dup, full, pick_lo, do_ins, do_inc, emit;
  logic [POS_W-1:0]    dlo, dhi, win_pos, rd_pos;
  logic [CNT_W-1:0]    win_cnt, inc_cnt, rd_cnt;
  logic [IDX_W-1:0]    win_idx;
  logic [POS_W-1:0]    o_pos;
  logic [CNT_W-1:0]    o_cnt;
  logic [IDX_W-1:0]    o_idx;
  status_t             o_st;
  logic                o_last;

  assign tbl_stat  = '{total: total, valid: valid};
  assign cmd_ready = (state == BK_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // parallel compare across all cells
  always_comb begin
    for (int i = 0; i < MAX_REFS; i++) begin
      lt_c[i] = valid[i] && (pos_tab[i] < cur.pos);
    end
  end

  // neighbors: largest below and smallest at or above the point
  always_comb begin
    plo_c = '0;
    phi_c = '0;
    clo_c = '0;
    chi_c = '0;
    for (int i = 0; i < MAX_REFS; i++) begin
      lo_oh[i] = lt[i] && ((i == MAX_REFS - 1) || !lt[(i + 1) % MAX_REFS]);
      hi_oh[i] = valid[i] && !lt[i] && ((i == 0) || lt[(i + MAX_REFS - 1) % MAX_REFS]);
      plo_c |= {POS_W{lo_oh[i]}} & pos_tab[i];
      clo_c |= {CNT_W{lo_oh[i]}} & cnt_tab[i];
      phi_c |= {POS_W{hi_oh[i]}} & pos_tab[i];
      chi_c |= {CNT_W{hi_oh[i]}} & cnt_tab[i];
    end
  end

  assign dup     = has_hi && (phi == cur.pos);
  assign full    = (total == TOT_W'(MAX_REFS));
  assign dlo     = cur.pos - plo;
  assign dhi     = phi - cur.pos;
  // tie goes to the smaller coordinate
  assign pick_lo = has_lo && (!has_hi || (dlo <= dhi));
  assign win_idx = pick_lo ? IDX_W'(rank - TOT_W'(1)) : rank[IDX_W-1:0];
  assign win_pos = pick_lo ? plo : phi;
  assign win_cnt = pick_lo ? clo : chi;
  assign inc_cnt = (&win_cnt) ? win_cnt : win_cnt + CNT_W'(1);
  assign rd_pos  = pos_tab[rd[IDX_W-1:0]];
  assign rd_cnt  = cnt_tab[rd[IDX_W-1:0]];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (cmd_valid) state_next = BK_CMP;
      BK_CMP:  state_next = (cur.func == FN_CLEAR) ? BK_IDLE : BK_SEL;
      BK_SEL:  state_next = BK_EXEC;
      BK_EXEC: begin
        if (cur.func == FN_READOUT && total != '0) state_next = BK_READ;
        else if (out_free) state_next = BK_IDLE;
      end
      BK_READ: if (out_free && (rd + TOT_W'(1) == total)) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // result selection
  always_comb begin
    emit   = 1'b0;
    o_pos  = '0;
    o_cnt  = '0;
    o_idx  = '0;
    o_st   = ST_OK;
    o_last = 1'b1;
    case (state)
      BK_EXEC: begin
        emit = out_free && !(cur.func == FN_READOUT && total != '0);
        case (cur.func)
          FN_LOAD: begin
            if (dup) begin
              o_pos = cur.pos;
              o_cnt = chi;
              o_idx = rank[IDX_W-1:0];
              o_st  = ST_DUP;
            end else if (full) begin
              o_st = ST_FULL;
            end else begin
              o_pos = cur.pos;
              o_idx = rank[IDX_W-1:0];
            end
          end
          FN_CLASSIFY: begin
            if (total == '0) begin
              o_st = ST_EMPTY;
            end else begin
              o_pos = win_pos;
              o_cnt = inc_cnt;
              o_idx = win_idx;
            end
          end
          default: o_st = ST_EMPTY;
        endcase
      end
      BK_READ: begin
        emit   = out_free;
        o_pos  = rd_pos;
        o_cnt  = rd_cnt;
        o_idx  = rd[IDX_W-1:0];
        o_last = (rd + TOT_W'(1) == total);
      end
      default: emit = 1'b0;
    endcase
  end

  assign do_ins = emit && (state == BK_EXEC) && (cur.func == FN_LOAD) && !dup && !full;
  assign do_inc = emit && (state == BK_EXEC) && (cur.func == FN_CLASSIFY) && (total != '0);

  // cell row: insert shifts the upper part up by one
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_REFS; i++) begin
      if (do_ins && !lt[i]) begin
        if (TOT_W'(i) == rank) begin
          pos_tab[i] <= cur.pos;
          cnt_tab[i] <= '0;
        end else if (i > 0) begin
          pos_tab[i] <= pos_tab[(i + MAX_REFS - 1) % MAX_REFS];
          cnt_tab[i] <= cnt_tab[(i + MAX_REFS - 1) % MAX_REFS];
        end
      end else if (do_inc && (IDX_W'(i) == win_idx)) begin
        cnt_tab[i] <= inc_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && cmd_valid) cur <= cmd;
    if (state == BK_CMP) lt <= lt_c;
    if (state == BK_SEL) begin
      rank   <= TOT_W'($countones(lt));
      has_lo <= |lt;
      has_hi <= |hi_oh;
      plo    <= plo_c;
      phi    <= phi_c;
      clo    <= clo_c;
      chi    <= chi_c;
    end
    if (emit) begin
      ref_position <= o_pos;
      hit_count    <= o_cnt;
      ref_index    <= o_idx;
      status       <= o_st;
      last         <= o_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      valid     <= '0;
      total     <= '0;
      rd        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CMP && cur.func == FN_CLEAR) begin
        valid <= '0;
        total <= '0;
      end else if (do_ins) begin
        valid <= {valid[MAX_REFS-2:0], 1'b1};
        total <= total + TOT_W'(1);
      end
      if (state == BK_EXEC) rd <= '0;
      else if (state == BK_READ && emit) rd <= rd + TOT_W'(1);
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ===== test/nearest_point_hit_counter_test.sv =====
// ----------------------------------------------------------------------------
// nearest_point_hit_counter_test
// Random and directed test of the sorted reference table: loads, nearest-point
// classification, readouts and clears, checked against a built-in predictor.
// ----------------------------------------------------------------------------
module nearest_point_hit_counter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nphc_pkg::*;

  typedef struct {
    logic [31:0] pos;
    logic [31:0] cnt;
    logic [5:0]  idx;
    status_t     st;
    logic        lst;
  } hit_result_t;

  class hit_table_scoreboard;
    logic [31:0] positions[64];
    logic [31:0] counts[64];
    int          total;
    hit_result_t pending[$];
    int          errors;
    int          checked;

    function void add(logic [31:0] p, logic [31:0] c, int i, status_t s, bit l);
      hit_result_t r;
      r.pos = p; r.cnt = c; r.idx = i[5:0]; r.st = s; r.lst = l;
      pending.insert(pending.size(), r);
    endfunction

    // predict results of one accepted transfer
    function void note_item(func_t f, logic [31:0] p);
      int rank;
      int best;
      logic [31:0] d;
      logic [31:0] best_d;
      rank = 0;
      best = 0;
      best_d = 0;
      case (f)
        FN_LOAD: begin
          while (rank < total && positions[rank] < p) rank++;
          if (rank < total && positions[rank] == p) begin
            add(p, counts[rank], rank, ST_DUP, 1);
          end else if (total >= 64) begin
            add(0, 0, 0, ST_FULL, 1);
          end else begin
            for (int i = total; i > rank; i--) begin
              positions[i] = positions[i-1];
              counts[i] = counts[i-1];
            end
            positions[rank] = p;
            counts[rank] = 0;
            total++;
            add(p, 0, rank, ST_OK, 1);
          end
        end
        FN_CLASSIFY: begin
          if (total == 0) begin
            add(0, 0, 0, ST_EMPTY, 1);
          end else begin
            for (int i = 0; i < total; i++) begin
              d = (positions[i] >= p) ? positions[i] - p : p - positions[i];
              if (i == 0 || d < best_d) begin
                best = i;
                best_d = d;
              end
            end
            if (counts[best] != 32'hFFFF_FFFF) counts[best]++;
            add(positions[best], counts[best], best, ST_OK, 1);
          end
        end
        FN_READOUT: begin
          if (total == 0) add(0, 0, 0, ST_EMPTY, 1);
          for (int i = 0; i < total; i++)
            add(positions[i], counts[i], i, ST_OK, i + 1 == total);
        end
        default: begin
          for (int i = 0; i < 64; i++) counts[i] = 0;
          total = 0;
        end
      endcase
    endfunction

    function void check_result(logic [31:0] p, logic [31:0] c, logic [5:0] i,
                               logic [1:0] s, logic l);
      hit_result_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result with nothing expected: pos %h", p);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (p !== e.pos) begin
        $error("ref_position exp %h got %h", e.pos, p); errors++;
      end
      if (c !== e.cnt) begin
        $error("hit_count exp %h got %h", e.cnt, c); errors++;
      end
      if (i !== e.idx) begin
        $error("ref_index exp %0d got %0d", e.idx, i); errors++;
      end
      if (s !== e.st) begin
        $error("status exp %0d got %0d", e.st, s); errors++;
      end
      if (l !== e.lst) begin
        $error("last exp %0d got %0d", e.lst, l); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  func = 0;
  logic [31:0] position = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] ref_position;
  logic [31:0] hit_count;
  logic [5:0]  ref_index;
  logic [1:0]  status;
  logic        last;

  hit_table_scoreboard sb = new();
  bit  calm = 0;        // no idling on either side
  bit  hold_off = 0;    // receiver long stall request
  int  quiet_cycles = 0;
  int  items_sent = 0;
  logic [31:0] pool[$];

  nearest_point_hit_counter i_dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  int hold_left = 0;
  function automatic bit hit_test_hold();
    return hold_left > 0;
  endfunction
  always @(posedge clk) begin
    if (hold_off && hold_left == 0) hold_left <= 150;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // receiver: random stalls, and a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result(ref_position, hit_count, ref_index, status, last);
      if (hit_test_hold()) begin
        out_stall <= 1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 31);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(func_t f, logic [31:0] p);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    position <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(f, p);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_position();
    int r;
    r = $urandom_range(9);
    if (r < 3 && pool.size() > 0) return pool[$urandom_range(pool.size() - 1)];
    if (r < 6 && pool.size() > 0)
      return pool[$urandom_range(pool.size() - 1)] + $urandom_range(8) - 4;
    return $urandom();
  endfunction

  initial begin
    func_t f;
    logic [31:0] p;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty cases, extremes, duplicate, tie, clear
    send_item(FN_CLASSIFY, 32'h0);
    send_item(FN_READOUT, 32'hFFFF_FFFF);
    send_item(FN_LOAD, 32'h0);
    send_item(FN_LOAD, 32'hFFFF_FFFF);
    send_item(FN_LOAD, 32'h0);
    send_item(FN_LOAD, 32'd100);
    send_item(FN_LOAD, 32'd110);
    send_item(FN_CLASSIFY, 32'd105);
    send_item(FN_CLASSIFY, 32'hFFFF_FFF0);
    send_item(FN_CLASSIFY, 32'h7FFF_FFFF);
    send_item(FN_LOAD, 32'd100);
    send_item(FN_READOUT, 32'h0);
    send_item(FN_CLEAR, 32'h1234_5678);
    send_item(FN_READOUT, 32'h0);
    // fill the table, then two more (full and duplicate), then read all 64
    for (int i = 0; i < 64; i++) send_item(FN_LOAD, i * 32'h0400_0000 + 32'd7);
    send_item(FN_LOAD, 32'd3);
    send_item(FN_LOAD, 32'd7);
    send_item(FN_READOUT, 32'h0);
    send_item(FN_CLEAR, 32'h0);

    // random part; a stretch without idling, with a receiver hold-off
    for (int n = 0; n < 140; n++) begin
      calm = (n >= 20 && n < 60);
      hold_off = (n == 30);
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: f = FN_LOAD;
        7, 8, 9, 10, 11, 12, 13, 14, 15: f = FN_CLASSIFY;
        16, 17, 18: f = FN_READOUT;
        default: f = FN_CLEAR;
      endcase
      p = pick_position();
      if (f == FN_LOAD) pool.insert(pool.size(), p);
      if (f == FN_CLEAR) pool.delete();
      send_item(f, p);
    end
    in_valid <= 0;
    hold_off = 0;
    calm = 0;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Ran %0d transfers in, %0d results checked: loads, duplicates,",
             items_sent, sb.checked);
    $display("full table, ties, empty classify and readout, clears.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
